FILE: src/rspg_pkg.sv
`timescale 1ns / 1ps

package rspg_pkg;

    // default sprite edge in pixels
    localparam int SPRITE_SIZE_DEF = 64;

    // root bits resolved per square root stage
    localparam int SQRT_STEPS = 4;

    // squared radius is scaled by 2^14 so the root carries 8 fraction bits
    localparam int SQRT_SHIFT = 14;

    // coverage is a fraction with 8 fraction bits, 0 .. 1.0
    localparam int COV_W = 9;
    localparam logic [COV_W-1:0] COV_ONE = 9'd256;
    localparam int TINT_W = 8;
    localparam logic [TINT_W-1:0] TINT_WHITE = 8'd255;

    // geometry in distance units with 8 fraction bits
    localparam int RING_RADIUS    = 6656;
    localparam int OUTLINE_RADIUS = 7424;
    localparam int RING_HALF      = 768;
    localparam int DOT_EDGE       = 640;
    localparam int OUTLINE_HALF   = 384;

    // outline strength 0.6 as (x * 3 + 2) / 5, divide by reciprocal
    localparam int OUTLINE_MUL   = 3;
    localparam int OUTLINE_ROUND = 2;
    localparam int RECIP_FIVE    = 205;
    localparam int RECIP_SHIFT   = 10;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TINT_RED   = 2'd0,
        CFG_TINT_GREEN = 2'd1,
        CFG_TINT_BLUE  = 2'd2,
        CFG_BLUE_FIRST = 2'd3
    } t_cfg_idx;

    // premultiplied byte: (tint * cov + 128) >> 8
    function automatic logic [TINT_W-1:0] colour_byte(input logic [TINT_W-1:0] tint,
                                                      input logic [COV_W-1:0] cov);
        logic [15:0] prod;
        prod = 16'(tint) * 16'(cov) + 16'd128;
        return prod[15:8];
    endfunction

endpackage

FILE: src/reticle_sprite_pixel_generator_unit.sv
`timescale 1ns / 1ps

// Reticle sprite pixel generator: give it a pixel coordinate of the square sprite and it
// returns the four premultiplied bytes of a tinted feathered ring with a white centre dot and
// a dark outline band. One pixel is taken every clock and results leave in the same order;
// the pipelined square root resolves four distance bits per stage, for a root of
// clog2(SPRITE_SIZE) + 9 bits. Either side may stall at any time without loss. Tint and byte
// order registers are written through the cfg port; the user must write them only while no
// pixel is in flight, as the block itself does not enforce this.
module reticle_sprite_pixel_generator_unit import rspg_pkg::*; #(
    parameter int SPRITE_SIZE = SPRITE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // pixel_x, pixel_y, zero padding
    input  logic [((2*$clog2(SPRITE_SIZE)+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // out_byte_0, out_byte_1, out_byte_2, out_byte_3
    output logic [31:0]              o_m_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [7:0]               i_cfg_data
);

    localparam int PW     = $clog2(SPRITE_SIZE);
    localparam int AW     = PW + 1;
    localparam int SQW    = 2 * AW + 1;
    localparam int RAD_W  = SQW + SQRT_SHIFT + 1;
    localparam int ROOT_W = RAD_W / 2;
    localparam int OPW    = COV_W + RECIP_SHIFT;
    localparam logic [AW-1:0] CENTRE2 = AW'(SPRITE_SIZE - 1);

    // configuration registers
    logic [TINT_W-1:0] r_tint_red, r_tint_green, r_tint_blue;
    logic              r_blue_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_red   <= TINT_WHITE;
            r_tint_green <= TINT_WHITE;
            r_tint_blue  <= TINT_WHITE;
            r_blue_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TINT_RED:   r_tint_red   <= i_cfg_data;
                CFG_TINT_GREEN: r_tint_green <= i_cfg_data;
                CFG_TINT_BLUE:  r_tint_blue  <= i_cfg_data;
                CFG_BLUE_FIRST: r_blue_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage ready chain
    logic sq_rdy, sqrt_in_rdy, sqrt_vld, c_rdy_c, c_rdy_d, c_rdy_o;
    logic r_sq_vld, r_c_vld, r_d_vld, r_o_vld;

    assign c_rdy_o = !r_o_vld || i_m_axis_tready;
    assign c_rdy_d = !r_d_vld || c_rdy_o;
    assign c_rdy_c = !r_c_vld || c_rdy_d;
    assign sq_rdy  = !r_sq_vld || sqrt_in_rdy;
    assign o_s_axis_tready = sq_rdy;

    // squared distance from the centre, in half pixels
    logic [PW-1:0]     c_px, c_py;
    logic [AW-1:0]     c_x2, c_y2, c_dx, c_dy;
    logic [2*AW-1:0]   c_dxx, c_dyy;
    logic [SQW-1:0]    n_sq, r_sq;

    assign c_px  = i_s_axis_tdata[PW-1:0];
    assign c_py  = i_s_axis_tdata[2*PW-1:PW];
    assign c_x2  = {c_px, 1'b0};
    assign c_y2  = {c_py, 1'b0};
    assign c_dx  = (c_x2 >= CENTRE2) ? c_x2 - CENTRE2 : CENTRE2 - c_x2;
    assign c_dy  = (c_y2 >= CENTRE2) ? c_y2 - CENTRE2 : CENTRE2 - c_y2;
    assign c_dxx = c_dx * c_dx;
    assign c_dyy = c_dy * c_dy;
    assign n_sq  = {1'b0, c_dxx} + {1'b0, c_dyy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else if (sq_rdy) begin
            r_sq_vld <= i_s_axis_tvalid;
        end
        if (sq_rdy && i_s_axis_tvalid) begin
            r_sq <= n_sq;
        end
    end

    // distance with 8 fraction bits
    logic [ROOT_W-1:0] c_dist;

    rspg_isqrt #(
        .RAD_W (RAD_W),
        .STEPS (SQRT_STEPS)
    ) u_isqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_sq_vld),
        .o_in_ready  (sqrt_in_rdy),
        .i_radicand  ({1'b0, r_sq, {SQRT_SHIFT{1'b0}}}),
        .o_out_valid (sqrt_vld),
        .i_out_ready (c_rdy_c),
        .o_root      (c_dist)
    );

    // feathered ramp: edge minus distance, clamped to 0 .. 1.0
    function automatic logic [COV_W-1:0] ramp(input logic [ROOT_W-1:0] dist_q8,
                                              input logic [ROOT_W-1:0] edge_v);
        logic [ROOT_W-1:0] rest;
        rest = edge_v - dist_q8;
        if (dist_q8 >= edge_v) begin
            return '0;
        end else if (rest >= ROOT_W'(COV_ONE)) begin
            return COV_ONE;
        end else begin
            return rest[COV_W-1:0];
        end
    endfunction

    function automatic logic [ROOT_W-1:0] abs_diff(input logic [ROOT_W-1:0] a,
                                                   input logic [ROOT_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // ring, dot and outline coverages
    logic [COV_W-1:0] r_c_ring, r_c_dot, r_c_oraw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (c_rdy_c) begin
            r_c_vld <= sqrt_vld;
        end
        if (c_rdy_c && sqrt_vld) begin
            r_c_ring <= ramp(abs_diff(c_dist, ROOT_W'(RING_RADIUS)), ROOT_W'(RING_HALF));
            r_c_dot  <= ramp(c_dist, ROOT_W'(DOT_EDGE));
            r_c_oraw <= ramp(abs_diff(c_dist, ROOT_W'(OUTLINE_RADIUS)),
                             ROOT_W'(OUTLINE_HALF));
        end
    end

    // outline strength, then pick coverage and colour
    logic [COV_W:0]    c_onum;
    logic [OPW-1:0]    c_oprod;
    logic [COV_W-1:0]  c_outline, c_a;
    logic [COV_W-1:0]  n_d_cov, r_d_cov;
    logic [TINT_W-1:0] n_d_red, n_d_green, n_d_blue;
    logic [TINT_W-1:0] r_d_red, r_d_green, r_d_blue;

    assign c_onum    = (COV_W+1)'(r_c_oraw) * (COV_W+1)'(OUTLINE_MUL)
                     + (COV_W+1)'(OUTLINE_ROUND);
    assign c_oprod   = OPW'(c_onum) * OPW'(RECIP_FIVE);
    assign c_outline = c_oprod[RECIP_SHIFT +: COV_W];
    assign c_a       = (r_c_ring > r_c_dot) ? r_c_ring : r_c_dot;

    always_comb begin
        n_d_cov   = c_a;
        n_d_red   = r_tint_red;
        n_d_green = r_tint_green;
        n_d_blue  = r_tint_blue;
        if (c_a == '0) begin
            n_d_cov = '0;
        end else if (c_outline > c_a) begin
            n_d_cov   = c_outline;
            n_d_red   = '0;
            n_d_green = '0;
            n_d_blue  = '0;
        end else if (r_c_dot >= r_c_ring) begin
            n_d_red   = TINT_WHITE;
            n_d_green = TINT_WHITE;
            n_d_blue  = TINT_WHITE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (c_rdy_d) begin
            r_d_vld <= r_c_vld;
        end
        if (c_rdy_d && r_c_vld) begin
            r_d_cov   <= n_d_cov;
            r_d_red   <= n_d_red;
            r_d_green <= n_d_green;
            r_d_blue  <= n_d_blue;
        end
    end

    // premultiply, order bytes, output register
    logic [TINT_W-1:0] c_red, c_green, c_blue, c_alpha;
    logic [31:0]       r_o_data;

    assign c_red   = colour_byte(r_d_red, r_d_cov);
    assign c_green = colour_byte(r_d_green, r_d_cov);
    assign c_blue  = colour_byte(r_d_blue, r_d_cov);
    assign c_alpha = colour_byte(TINT_WHITE, r_d_cov);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (c_rdy_o) begin
            r_o_vld <= r_d_vld;
        end
        if (c_rdy_o && r_d_vld) begin
            r_o_data <= r_blue_first ? {c_alpha, c_red, c_green, c_blue}
                                     : {c_alpha, c_blue, c_green, c_red};
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_data;

    // a beat taken at the input always lands in the first stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_sq_vld)
        else $error("accepted beat lost at first stage");

    // selected coverage never exceeds 1.0
    a_cov_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld |-> r_d_cov <= COV_ONE)
        else $error("coverage above one");

    // premultiplied colour never exceeds alpha
    a_premul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:0] <= o_m_axis_tdata[31:24])
                         && (o_m_axis_tdata[15:8] <= o_m_axis_tdata[31:24])
                         && (o_m_axis_tdata[23:16] <= o_m_axis_tdata[31:24]))
        else $error("colour byte above alpha");

    // transparent pixels carry no colour
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[31:24] == 8'd0) |-> o_m_axis_tdata[23:0] == 24'd0)
        else $error("colour on transparent pixel");

endmodule

FILE: src/rspg_isqrt.sv
`timescale 1ns / 1ps

module rspg_isqrt import rspg_pkg::*; #(
    parameter int RAD_W = 30,
    parameter int STEPS = SQRT_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [RAD_W-1:0]     i_radicand,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [RAD_W/2-1:0]   o_root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int NST    = (ROOT_W + STEPS - 1) / STEPS;

    logic [RAD_W-1:0]  r_rad  [NST];
    logic [ROOT_W+1:0] r_rem  [NST];
    logic [ROOT_W-1:0] r_root [NST];
    logic [NST-1:0]    r_vld;
    logic [NST:0]      c_rdy;

    assign c_rdy[NST] = i_out_ready;

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic [RAD_W-1:0]  c_rad_in;
        logic [ROOT_W+1:0] c_rem_in;
        logic [ROOT_W-1:0] c_root_in;
        logic              c_vld_in;
        logic [RAD_W-1:0]  n_rad;
        logic [ROOT_W+1:0] n_rem;
        logic [ROOT_W-1:0] n_root;

        // stage input from the port or the previous stage
        if (k == 0) begin : g_first
            assign c_rad_in  = i_radicand;
            assign c_rem_in  = '0;
            assign c_root_in = '0;
            assign c_vld_in  = i_in_valid;
        end else begin : g_next
            assign c_rad_in  = r_rad[k-1];
            assign c_rem_in  = r_rem[k-1];
            assign c_root_in = r_root[k-1];
            assign c_vld_in  = r_vld[k-1];
        end

        assign c_rdy[k] = !r_vld[k] || c_rdy[k+1];

        // up to STEPS digit-by-digit root steps, two radicand bits each
        always_comb begin
            logic [ROOT_W+1:0] trial;
            n_rad  = c_rad_in;
            n_rem  = c_rem_in;
            n_root = c_root_in;
            trial  = '0;
            for (int j = 0; j < STEPS; j++) begin
                if (k * STEPS + j < ROOT_W) begin
                    n_rem = {n_rem[ROOT_W-1:0], n_rad[RAD_W-1 -: 2]};
                    n_rad = {n_rad[RAD_W-3:0], 2'b00};
                    trial = {n_root, 2'b01};
                    if (n_rem >= trial) begin
                        n_rem  = n_rem - trial;
                        n_root = {n_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        // stage register
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (c_rdy[k]) begin
                r_vld[k] <= c_vld_in;
            end
            if (c_rdy[k] && c_vld_in) begin
                r_rad[k]  <= n_rad;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_in_ready  = c_rdy[0];
    assign o_out_valid = r_vld[NST-1];
    assign o_root      = r_root[NST-1];

endmodule
